@@ rtl/core/dls_pkg.sv @@
// ---------------------------------------------------------------------------
// dls_pkg: shared types, codes and table math for the dense sigmoid layer
// Command and register codes, pipeline tag structs, saturating add and the
// sigmoid table entry function used to build the lookup ROM.
// ---------------------------------------------------------------------------
package dls_pkg;

  localparam int OUT_MAX_DEF     = 32;
  localparam int IN_MAX_DEF      = 1024;
  localparam int SIG_ENTRIES_DEF = 256;

  localparam int NEURON_W = 5;
  localparam int VALUE_W  = 16;
  localparam int ACT_W    = 13;
  localparam int ACC_W    = 40;

  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_ACT    = 2'd2;

  localparam logic REG_OUT_COUNT = 1'b0;
  localparam logic REG_IN_COUNT  = 1'b1;

  localparam logic [5:0]  OUT_COUNT_RST = 6'd10;
  localparam logic [10:0] IN_COUNT_RST  = 11'd784;

  // One multiply-accumulate slot travelling down the pipeline
  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last;
    logic                fin;
    logic                zero;
    logic [NEURON_W-1:0] row;
  } slot_t;

  // One finished row sum
  typedef struct packed {
    logic                valid;
    logic                fin;
    logic [NEURON_W-1:0] row;
  } res_t;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // Sigmoid of a Q4.12 input, Q4.12 result 0..4096; elaboration use only
  function automatic logic [ACT_W-1:0] sig_value(input longint xq);
    longint unsigned one;
    longint unsigned ax;
    longint unsigned y;
    longint unsigned t2;
    longint unsigned t3;
    longint unsigned t4;
    longint unsigned r;
    longint unsigned den;
    longint unsigned num;
    longint unsigned rem;
    longint unsigned q;
    logic [ACT_W-1:0] sig;
    one = 64'd1 << 30;
    ax  = (xq < 0) ? longint'(-xq) : longint'(xq);
    y   = ax << 10;
    t2  = ((y * y) >> 30) / 2;
    t3  = ((t2 * y) >> 30) / 3;
    t4  = ((t3 * y) >> 30) / 4;
    r   = one - y + t2 - t3 + t4;
    for (int k = 0; k < 8; k++) begin
      r = (r * r + (one >> 1)) >> 30;
    end
    den = one + r;
    num = (64'd4096 << 30) + (den >> 1);
    rem = 0;
    q   = 0;
    for (int i = 43; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'd1 << i);
      end
    end
    sig = ACT_W'(q);
    return (xq >= 0) ? sig : ACT_W'(13'd4096 - sig);
  endfunction

endpackage

@@ rtl/core/dls_store.sv @@
// ---------------------------------------------------------------------------
// dls_store: weight, activation and bias memories
// Single write port per memory from the load path, one registered read per
// cycle driven by the row/column sequencer. The slot tag follows the data.
// ---------------------------------------------------------------------------
module dls_store #(
  parameter int  OUT_MAX = dls_pkg::OUT_MAX_DEF,
  parameter int  IN_MAX  = dls_pkg::IN_MAX_DEF,
  localparam int WADDR_W = (OUT_MAX * IN_MAX > 1) ? $clog2(OUT_MAX * IN_MAX) : 1,
  localparam int COL_W   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1,
  localparam int ROW_W   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            w_we,
  input  logic [WADDR_W-1:0]              w_waddr,
  input  logic                            a_we,
  input  logic [COL_W-1:0]                a_waddr,
  input  logic                            b_we,
  input  logic [ROW_W-1:0]                b_waddr,
  input  logic [dls_pkg::VALUE_W-1:0]     wdata,
  input  dls_pkg::slot_t                  slot_in,
  input  logic [WADDR_W-1:0]              rd_waddr,
  input  logic [COL_W-1:0]                rd_aaddr,
  input  logic [ROW_W-1:0]                rd_baddr,
  output dls_pkg::slot_t                  slot_out,
  output logic [dls_pkg::VALUE_W-1:0]     w_rdata,
  output logic [dls_pkg::VALUE_W-1:0]     a_rdata,
  output logic [dls_pkg::VALUE_W-1:0]     b_rdata
);

  logic [dls_pkg::VALUE_W-1:0] wmem [OUT_MAX * IN_MAX];
  logic [dls_pkg::VALUE_W-1:0] amem [IN_MAX];
  logic [dls_pkg::VALUE_W-1:0] bmem [OUT_MAX];

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= wdata;
    end
    if (slot_in.valid) begin
      w_rdata <= wmem[rd_waddr];
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= wdata;
    end
    if (slot_in.valid) begin
      a_rdata <= amem[rd_aaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_waddr] <= wdata;
    end
    if (slot_in.valid) begin
      b_rdata <= bmem[rd_baddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_out <= '0;
    end else begin
      slot_out <= slot_in;
    end
  end

endmodule

@@ rtl/core/dls_mac.sv @@
// ---------------------------------------------------------------------------
// dls_mac: multiply, saturating accumulate and bias add
// Three stages: registered product, 40-bit accumulator, row total with bias.
// ---------------------------------------------------------------------------
module dls_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  dls_pkg::slot_t                      slot_in,
  input  logic [dls_pkg::VALUE_W-1:0]         w_rdata,
  input  logic [dls_pkg::VALUE_W-1:0]         a_rdata,
  input  logic [dls_pkg::VALUE_W-1:0]         b_rdata,
  output dls_pkg::res_t                       res,
  output logic signed [dls_pkg::ACC_W-1:0]    total
);

  localparam int AW = dls_pkg::ACC_W;
  localparam int VW = dls_pkg::VALUE_W;

  dls_pkg::slot_t           slot_p;
  dls_pkg::slot_t           slot_a;
  logic signed [2*VW-1:0]   prod;
  logic [VW-1:0]            bias_p;
  logic [VW-1:0]            bias_a;
  logic signed [AW-1:0]     acc;
  logic signed [AW-1:0]     acc_next;
  logic signed [AW-1:0]     prod_ext;
  logic signed [AW-1:0]     bias_ext;

  // Stage 1: product (forced to zero when the row has no columns)
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_p <= '0;
    end else begin
      slot_p <= slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_in.zero) begin
      prod <= '0;
    end else begin
      prod <= $signed(w_rdata) * $signed(a_rdata);
    end
    bias_p <= b_rdata;
  end

  // Stage 2: accumulate, restart on the first column of a row
  assign prod_ext = {{(AW-2*VW){prod[2*VW-1]}}, prod};
  assign acc_next = dls_pkg::sat_add(slot_p.first ? '0 : acc, prod_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_a <= '0;
      acc    <= '0;
    end else begin
      slot_a <= slot_p;
      if (slot_p.valid) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    bias_a <= bias_p;
  end

  // Stage 3: add the bias scaled to Q16.24 once the row is complete
  assign bias_ext = {{(AW-VW-12){bias_a[VW-1]}}, bias_a, 12'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else begin
      res.valid <= slot_a.valid & slot_a.last;
      res.fin   <= slot_a.fin;
      res.row   <= slot_a.row;
    end
  end

  always_ff @(posedge clk) begin
    total <= dls_pkg::sat_add(acc, bias_ext);
  end

endmodule

@@ rtl/core/dls_sigmoid.sv @@
// ---------------------------------------------------------------------------
// dls_sigmoid: clamp, table index and sigmoid lookup
// Clamps the Q16.24 row total to the Q4.12 range, scales it to a table index
// and drives the registered result word.
// ---------------------------------------------------------------------------
module dls_sigmoid #(
  parameter int SIG_ENTRIES = dls_pkg::SIG_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dls_pkg::res_t                       res,
  input  logic signed [dls_pkg::ACC_W-1:0]    total,
  output logic                                strobe,
  output logic [dls_pkg::NEURON_W-1:0]        neuron,
  output logic [dls_pkg::ACT_W-1:0]           activation,
  output logic                                final_res
);

  localparam int AW    = dls_pkg::ACC_W;
  localparam int IDX_W = $clog2(SIG_ENTRIES);
  localparam int PW    = 16 + $clog2(SIG_ENTRIES + 1);

  logic [dls_pkg::ACT_W-1:0] sig_rom [SIG_ENTRIES];
  logic [27:0]               xc;
  logic [15:0]               u;
  logic [PW-1:0]             scaled;
  logic [IDX_W-1:0]          idx;
  dls_pkg::res_t             res_q;

  for (genvar g = 0; g < SIG_ENTRIES; g++) begin : g_rom
    localparam longint XQ = ((longint'(g) * 65536) / SIG_ENTRIES) - 32768;
    assign sig_rom[g] = dls_pkg::sig_value(XQ);
  end

  always_comb begin
    if (total > AW'(signed'(28'sh7FF_FFFF))) begin
      xc = 28'h7FF_FFFF;
    end else if (total < AW'(signed'(28'sh800_0000))) begin
      xc = 28'h800_0000;
    end else begin
      xc = total[27:0];
    end
    // offset by 2^27 and drop the fraction below Q4.12
    u      = {~xc[27], xc[26:12]};
    scaled = PW'(u) * PW'(SIG_ENTRIES);
  end

  always_ff @(posedge clk) begin
    idx <= IDX_W'(scaled >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_q  <= '0;
      strobe <= 1'b0;
    end else begin
      res_q  <= res;
      strobe <= res_q.valid;
    end
  end

  always_ff @(posedge clk) begin
    activation <= sig_rom[idx];
    neuron     <= res_q.row;
    final_res  <= res_q.fin;
  end

endmodule

@@ rtl/core/dense_layer_sigmoid.sv @@
// ---------------------------------------------------------------------------
// dense_layer_sigmoid: fully connected layer with sigmoid activation
// Loads weights, biases and input activations into on-chip memories, then
// computes sigmoid(W*a + b) in Q4.12, one result word per neuron row.
// ---------------------------------------------------------------------------
// A command word is taken on any clock edge with start high and busy low.
// Only an activation write with last set and a nonzero out_count raises
// busy, and it runs the layer: the sequencer reads one weight/activation
// pair per cycle from the memories, issuing rows * max(cols,1) pairs,
// where rows = min(out_count, OUT_MAX) and cols = min(in_count, IN_MAX);
// the weight memory read port sets that rate. After its last column is
// issued, each row's result passes the read, product, accumulator, total,
// index and table registers; busy drops on the cycle after the word with
// final_res. Result words are shown for exactly one cycle with strobe high;
// the receiver cannot stall them, so capture every strobe. Reads of memory
// entries never written return unspecified data. Write out_count and
// in_count only while busy is low.
// ---------------------------------------------------------------------------
module dense_layer_sigmoid #(
  parameter int OUT_MAX     = dls_pkg::OUT_MAX_DEF,
  parameter int IN_MAX      = dls_pkg::IN_MAX_DEF,
  parameter int SIG_ENTRIES = dls_pkg::SIG_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [10:0]                       cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd,
  input  logic [4:0]                        row,
  input  logic [9:0]                        col,
  input  logic signed [15:0]                value,
  input  logic                              last,
  output logic                              strobe,
  output logic [4:0]                        neuron,
  output logic [12:0]                       activation,
  output logic                              final_res
);

  localparam int WADDR_W = (OUT_MAX * IN_MAX > 1) ? $clog2(OUT_MAX * IN_MAX) : 1;
  localparam int COL_W   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int ROW_W   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int NW      = dls_pkg::NEURON_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]           state;
  logic [5:0]           out_count;
  logic [10:0]          in_count;
  logic                 accept;
  logic                 go;
  logic [6:0]           rows_eff;
  logic [12:0]          cols_eff;
  logic [ROW_W-1:0]     rows_m1;
  logic [COL_W-1:0]     cols_m1;
  logic                 no_cols;
  logic [ROW_W-1:0]     row_idx;
  logic [COL_W-1:0]     col_idx;
  logic [WADDR_W-1:0]   wbase;
  logic                 w_we;
  logic                 a_we;
  logic                 b_we;
  logic [WADDR_W-1:0]   w_waddr;
  dls_pkg::slot_t       slot_iss;
  dls_pkg::slot_t       slot_rd;
  dls_pkg::res_t        res;
  logic signed [dls_pkg::ACC_W-1:0] total;
  logic [15:0]          w_rdata;
  logic [15:0]          a_rdata;
  logic [15:0]          b_rdata;

  assign busy   = (state != S_IDLE);
  assign accept = start & ~busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= dls_pkg::OUT_COUNT_RST;
      in_count  <= dls_pkg::IN_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dls_pkg::REG_OUT_COUNT: out_count <= cfg_data[5:0];
        dls_pkg::REG_IN_COUNT:  in_count  <= cfg_data;
        default:                ;
      endcase
    end
  end

  // Load path: drop writes that fall outside the stores
  assign w_we    = accept && (cmd == dls_pkg::CMD_WEIGHT) &&
                   (32'(row) < OUT_MAX) && (32'(col) < IN_MAX);
  assign b_we    = accept && (cmd == dls_pkg::CMD_BIAS) && (32'(row) < OUT_MAX);
  assign a_we    = accept && (cmd == dls_pkg::CMD_ACT) && (32'(col) < IN_MAX);
  assign w_waddr = WADDR_W'(32'(row) * IN_MAX + 32'(col));

  // Effective sizes, saturated to the store dimensions
  assign rows_eff = (7'(out_count) > 7'(OUT_MAX)) ? 7'(OUT_MAX) : 7'(out_count);
  assign cols_eff = (13'(in_count) > 13'(IN_MAX)) ? 13'(IN_MAX) : 13'(in_count);
  assign go       = accept && (cmd == dls_pkg::CMD_ACT) && last;

  // Issue slot for the current (row, column) read
  always_comb begin
    slot_iss.valid = (state == S_RUN);
    slot_iss.first = (col_idx == '0);
    slot_iss.last  = (col_idx == cols_m1);
    slot_iss.fin   = (col_idx == cols_m1) && (row_idx == rows_m1);
    slot_iss.zero  = no_cols;
    slot_iss.row   = NW'(row_idx);
  end

  // Row/column sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go && (rows_eff != '0)) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (slot_iss.fin) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // hold until the last row's word has gone out
          if (strobe && final_res) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      row_idx <= '0;
      col_idx <= '0;
      wbase   <= '0;
      if (go) begin
        rows_m1 <= ROW_W'(rows_eff - 7'd1);
        cols_m1 <= (cols_eff == '0) ? '0 : COL_W'(cols_eff - 13'd1);
        no_cols <= (cols_eff == '0);
      end
    end else if (state == S_RUN) begin
      if (slot_iss.last) begin
        col_idx <= '0;
        row_idx <= row_idx + ROW_W'(1);
        wbase   <= wbase + WADDR_W'(IN_MAX);
      end else begin
        col_idx <= col_idx + COL_W'(1);
      end
    end
  end

  dls_store #(
    .OUT_MAX (OUT_MAX),
    .IN_MAX  (IN_MAX)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .w_we     (w_we),
    .w_waddr  (w_waddr),
    .a_we     (a_we),
    .a_waddr  (COL_W'(col)),
    .b_we     (b_we),
    .b_waddr  (ROW_W'(row)),
    .wdata    (value),
    .slot_in  (slot_iss),
    .rd_waddr (wbase + WADDR_W'(col_idx)),
    .rd_aaddr (col_idx),
    .rd_baddr (row_idx),
    .slot_out (slot_rd),
    .w_rdata  (w_rdata),
    .a_rdata  (a_rdata),
    .b_rdata  (b_rdata)
  );

  dls_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .slot_in (slot_rd),
    .w_rdata (w_rdata),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .res     (res),
    .total   (total)
  );

  dls_sigmoid #(
    .SIG_ENTRIES (SIG_ENTRIES)
  ) u_sigmoid (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .total      (total),
    .strobe     (strobe),
    .neuron     (neuron),
    .activation (activation),
    .final_res  (final_res)
  );

endmodule

@@ rtl/core/dls_checker.sv @@
// ---------------------------------------------------------------------------
// dls_checker: port-level checks for the dense sigmoid layer
// Watches the command and result ports and is bound to the top level.
// ---------------------------------------------------------------------------
module dls_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] cmd,
  input logic       last,
  input logic       strobe,
  input logic [4:0] neuron,
  input logic       final_res
);

  // results only come out of a running layer
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result word outside a layer run");

  // the final row ends the run
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && final_res |=> !busy)
    else $error("busy held after final result word");

  // load words never stall the command side
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !(cmd == dls_pkg::CMD_ACT && last) |=> !busy)
    else $error("load word raised busy");

  // a run only begins from an accepted command word
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command word");

  // back-to-back results walk the rows in order
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(strobe) && !$past(final_res) |-> neuron == 5'($past(neuron) + 5'd1))
    else $error("result rows out of order");

endmodule

bind dense_layer_sigmoid dls_checker u_dls_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .cmd       (cmd),
  .last      (last),
  .strobe    (strobe),
  .neuron    (neuron),
  .final_res (final_res)
);
